// ----- rtl/mrs_pkg.sv -----
// mrs_pkg: shared types, codes, limits and helpers of the mash rest sequencer
// used by every module under rtl; depends on nothing else
package mrs_pkg;

    // target and rest limits
    localparam int MIN_TARGET         = -880;
    localparam int MAX_TARGET         = 2000;
    localparam int MAX_REST_MINUTES   = 255;
    localparam int SECONDS_PER_MINUTE = 60;

    // field widths
    localparam int TEMP_W      = 12;
    localparam int MIN_W       = 8;
    localparam int LEFT_W      = 14;
    localparam int TIME_W      = 32;
    localparam int PHASE_W     = 3;
    localparam int REQ_STATE_W = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int DIFF_W      = TIME_W + 3;

    // seconds-left ceiling and effective minute ceiling
    localparam int LEFT_MAX_I  = (1 << LEFT_W) - 1;
    localparam int LEFT_CAP_I  = (SECONDS_PER_MINUTE * MAX_REST_MINUTES > LEFT_MAX_I) ?
                                 LEFT_MAX_I : SECONDS_PER_MINUTE * MAX_REST_MINUTES;
    localparam int MIN_LIMIT_I = (MAX_REST_MINUTES > (1 << MIN_W) - 1) ?
                                 (1 << MIN_W) - 1 : MAX_REST_MINUTES;

    typedef logic signed [TEMP_W-1:0] t_temp;
    typedef logic [MIN_W-1:0]         t_minutes;
    typedef logic [LEFT_W-1:0]        t_left;
    typedef logic [TIME_W-1:0]        t_time;
    typedef logic [PHASE_W-1:0]       t_phase;

    localparam t_left    LEFT_CAP       = t_left'(LEFT_CAP_I);
    localparam t_minutes REST_MIN_LIMIT = t_minutes'(MIN_LIMIT_I);
    localparam t_left    SEC_PER_MIN    = t_left'(SECONDS_PER_MINUTE);
    localparam t_temp    TEMP_MIN       = t_temp'(MIN_TARGET);
    localparam t_temp    TEMP_MAX       = t_temp'(MAX_TARGET);

    // process phases
    localparam t_phase PH_IDLE   = 3'd0;
    localparam t_phase PH_HEAT_1 = 3'd1;
    localparam t_phase PH_HOLD_1 = 3'd2;
    localparam t_phase PH_HEAT_2 = 3'd3;
    localparam t_phase PH_HOLD_2 = 3'd4;
    localparam t_phase PH_HEAT_3 = 3'd5;
    localparam t_phase PH_HOLD_3 = 3'd6;
    localparam t_phase PH_DONE   = 3'd7;

    // register reset values
    localparam t_temp    RST_REST_TEMP_1 = 12'sd800;
    localparam t_temp    RST_REST_TEMP_2 = 12'sd1008;
    localparam t_temp    RST_REST_TEMP_3 = 12'sd1152;
    localparam t_minutes RST_REST_MIN_1  = 8'd20;
    localparam t_minutes RST_REST_MIN_2  = 8'd40;
    localparam t_minutes RST_REST_MIN_3  = 8'd20;
    localparam t_temp    RST_IDLE_TARGET = 12'sd320;

    typedef enum logic [1:0] {
        OP_TICK        = 2'd0,
        OP_SET_STATE   = 2'd1,
        OP_SET_CONTROL = 2'd2,
        OP_SET_TARGET  = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REST_TEMP_1  = 3'd0,
        CFG_REST_TEMP_2  = 3'd1,
        CFG_REST_TEMP_3  = 3'd2,
        CFG_REST_MIN_1   = 3'd3,
        CFG_REST_MIN_2   = 3'd4,
        CFG_REST_MIN_3   = 3'd5,
        CFG_IDLE_TARGET  = 3'd6
    } t_cfg_index;

    // register values as the sequencer sees them, already limited
    typedef struct packed {
        t_temp    rest_temp_1;
        t_temp    rest_temp_2;
        t_temp    rest_temp_3;
        t_minutes rest_min_1;
        t_minutes rest_min_2;
        t_minutes rest_min_3;
        t_temp    idle_target;
    } t_cfg;

    typedef struct packed {
        t_opcode                 opcode;
        t_temp                   temperature;
        t_time                   now_seconds;
        logic [REQ_STATE_W-1:0]  new_state;
        logic                    enable_value;
        t_temp                   new_target;
    } t_item;

    typedef struct packed {
        t_phase process_state;
        t_temp  target_temp;
        logic   control_on;
        t_left  rest_left_seconds;
        logic   command_rejected;
    } t_result;

    function automatic t_temp clamp_temp(input t_temp t);
        t_temp r;
        r = t;
        if (t > TEMP_MAX) r = TEMP_MAX;
        if (t < TEMP_MIN) r = TEMP_MIN;
        return r;
    endfunction

    function automatic t_minutes clamp_minutes(input t_minutes m);
        return (m > REST_MIN_LIMIT) ? REST_MIN_LIMIT : m;
    endfunction

endpackage

// ----- rtl/mash_rest_sequencer.sv -----
// mash_rest_sequencer: three-rest mash temperature sequencer, top level
// depends on mrs_pkg, mrs_cfg_regs and mrs_seq_core
//
//  channel  | dir | handshake                     | payload
//  ---------+-----+-------------------------------+------------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tuser opcode, tdata item fields
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tuser rejected, tdata result fields
//  cfg      | in  | i_cfg_wr_en                   | i_cfg_index, i_cfg_data
//
// one item per cycle sustained while the output is not stalled; an item waits in the input register
// until the output register is free, and its result is then registered there
// the state update is combinational: compares, a 35-bit add and subtract, a multiply and selects
// reset is synchronous, active low, and brings the valid flags, config and state registers to their defaults
// a stalled output holds its result; the input register still takes one item
module mash_rest_sequencer
    import mrs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // item input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [11:0] temperature, [43:12] now_seconds, [47:44] new_state,
    // [48] enable_value, [60:49] new_target, [63:61] zero
    input  logic [63:0]           s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]            s_axis_tuser,
    // result output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [2:0] process_state, [14:3] target_temp, [15] control_on,
    // [29:16] rest_left_seconds, [31:30] zero
    output logic [31:0]           m_axis_tdata,
    // [0] command_rejected
    output logic                  m_axis_tuser
);

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_result core_result;
    t_result r_out;
    logic    r_out_valid;
    logic    out_free, step, accept;

    mrs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // pipeline flow control
    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.opcode       <= t_opcode'(s_axis_tuser);
            r_item.temperature  <= t_temp'(s_axis_tdata[11:0]);
            r_item.now_seconds  <= s_axis_tdata[43:12];
            r_item.new_state    <= s_axis_tdata[47:44];
            r_item.enable_value <= s_axis_tdata[48];
            r_item.new_target   <= t_temp'(s_axis_tdata[60:49]);
        end
    end

    mrs_seq_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.rest_left_seconds, r_out.control_on,
                            r_out.target_temp, r_out.process_state};
    assign m_axis_tuser  = r_out.command_rejected;

endmodule

// ----- rtl/mrs_cfg_regs.sv -----
// mrs_cfg_regs: rest profile and idle target registers with their write port
// depends on mrs_pkg; presents the values already limited to the legal range
module mrs_cfg_regs
    import mrs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_temp    r_rest_temp_1, r_rest_temp_2, r_rest_temp_3, r_idle_target;
    t_minutes r_rest_min_1, r_rest_min_2, r_rest_min_3;

    // register writes, unused index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest_temp_1 <= RST_REST_TEMP_1;
            r_rest_temp_2 <= RST_REST_TEMP_2;
            r_rest_temp_3 <= RST_REST_TEMP_3;
            r_rest_min_1  <= RST_REST_MIN_1;
            r_rest_min_2  <= RST_REST_MIN_2;
            r_rest_min_3  <= RST_REST_MIN_3;
            r_idle_target <= RST_IDLE_TARGET;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_REST_TEMP_1: r_rest_temp_1 <= t_temp'(i_cfg_data);
                CFG_REST_TEMP_2: r_rest_temp_2 <= t_temp'(i_cfg_data);
                CFG_REST_TEMP_3: r_rest_temp_3 <= t_temp'(i_cfg_data);
                CFG_REST_MIN_1:  r_rest_min_1  <= i_cfg_data[MIN_W-1:0];
                CFG_REST_MIN_2:  r_rest_min_2  <= i_cfg_data[MIN_W-1:0];
                CFG_REST_MIN_3:  r_rest_min_3  <= i_cfg_data[MIN_W-1:0];
                CFG_IDLE_TARGET: r_idle_target <= t_temp'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // limited view
    assign o_cfg.rest_temp_1 = clamp_temp(r_rest_temp_1);
    assign o_cfg.rest_temp_2 = clamp_temp(r_rest_temp_2);
    assign o_cfg.rest_temp_3 = clamp_temp(r_rest_temp_3);
    assign o_cfg.rest_min_1  = clamp_minutes(r_rest_min_1);
    assign o_cfg.rest_min_2  = clamp_minutes(r_rest_min_2);
    assign o_cfg.rest_min_3  = clamp_minutes(r_rest_min_3);
    assign o_cfg.idle_target = clamp_temp(r_idle_target);

endmodule

// ----- rtl/mrs_seq_core.sv -----
// mrs_seq_core: process state registers and the per-item update logic
// depends on mrs_pkg; the caller strobes i_step once per item that moves on
module mrs_seq_core
    import mrs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_phase r_phase, n_phase;
    t_temp  r_target, n_target;
    logic   r_control, n_control;
    t_time  r_rest_start, n_rest_start;
    t_left  r_rest_left, n_rest_left;
    logic   r_pending, n_pending;
    logic   rejected;

    // rest selected by the current phase
    t_temp               rest_cur, rest_nxt;
    t_minutes            rest_min;
    logic                in_rest, has_next;
    t_left               rest_secs;
    logic signed [DIFF_W-1:0] diff;

    always_comb begin
        in_rest  = 1'b1;
        has_next = 1'b1;
        rest_cur = i_cfg.rest_temp_1;
        rest_nxt = i_cfg.rest_temp_2;
        rest_min = i_cfg.rest_min_1;
        case (r_phase)
            PH_HEAT_1, PH_HOLD_1: begin
                rest_cur = i_cfg.rest_temp_1;
                rest_nxt = i_cfg.rest_temp_2;
                rest_min = i_cfg.rest_min_1;
            end
            PH_HEAT_2, PH_HOLD_2: begin
                rest_cur = i_cfg.rest_temp_2;
                rest_nxt = i_cfg.rest_temp_3;
                rest_min = i_cfg.rest_min_2;
            end
            PH_HEAT_3, PH_HOLD_3: begin
                rest_cur = i_cfg.rest_temp_3;
                rest_nxt = i_cfg.rest_temp_3;
                rest_min = i_cfg.rest_min_3;
                has_next = 1'b0;
            end
            default: begin
                in_rest  = 1'b0;
                has_next = 1'b0;
            end
        endcase
    end

    // hold length in seconds and time still to go
    assign rest_secs = t_left'({{(LEFT_W-MIN_W){1'b0}}, rest_min} * SEC_PER_MIN);
    assign diff = $signed({3'b000, r_rest_start})
                + $signed({{(DIFF_W-LEFT_W){1'b0}}, rest_secs})
                - $signed({3'b000, i_item.now_seconds});

    // next state for one item
    always_comb begin
        n_phase      = r_phase;
        n_target     = r_target;
        n_control    = r_control;
        n_rest_start = r_rest_start;
        n_rest_left  = r_rest_left;
        n_pending    = r_pending;
        rejected     = 1'b0;
        case (i_item.opcode)
            OP_TICK: begin
                if (in_rest) begin
                    n_target  = rest_cur;
                    n_pending = 1'b0;
                    if (r_phase[0]) begin
                        // heating: wait for the rest temperature
                        n_rest_left = '0;
                        if (i_item.temperature >= rest_cur) begin
                            n_rest_start = i_item.now_seconds;
                            if (has_next && rest_min == '0) n_target = rest_nxt;
                            n_rest_left = (rest_secs > LEFT_CAP) ? LEFT_CAP : rest_secs;
                            n_phase     = r_phase + 3'd1;
                        end
                    end else begin
                        // holding: count the rest down
                        if (diff[DIFF_W-1] || diff == '0) begin
                            if (has_next) n_target = rest_nxt;
                            n_rest_left = '0;
                            n_phase     = r_phase + 3'd1;
                        end else if (diff > $signed({{(DIFF_W-LEFT_W){1'b0}}, LEFT_CAP})) begin
                            n_rest_left = LEFT_CAP;
                        end else begin
                            n_rest_left = diff[LEFT_W-1:0];
                        end
                    end
                end
                // tick after done resets the process
                if (n_pending) begin
                    n_phase   = PH_IDLE;
                    n_control = 1'b0;
                    n_target  = i_cfg.idle_target;
                    n_pending = 1'b0;
                end
                if (n_phase == PH_DONE) n_pending = 1'b1;
            end
            OP_SET_STATE: begin
                if (i_item.new_state[REQ_STATE_W-1]) begin
                    rejected = 1'b1;
                end else begin
                    n_phase = i_item.new_state[PHASE_W-1:0];
                    if (n_phase == PH_IDLE) begin
                        n_control = 1'b0;
                        n_target  = i_cfg.idle_target;
                    end else begin
                        n_control = 1'b1;
                        if (!n_phase[0]) n_rest_start = i_item.now_seconds;
                    end
                end
            end
            OP_SET_CONTROL: begin
                if (r_phase != PH_IDLE) rejected = 1'b1;
                else n_control = i_item.enable_value;
            end
            OP_SET_TARGET: begin
                if (r_phase != PH_IDLE) rejected = 1'b1;
                else n_target = clamp_temp(i_item.new_target);
            end
            default: begin
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_target     <= clamp_temp(RST_IDLE_TARGET);
            r_control    <= 1'b0;
            r_rest_start <= '0;
            r_rest_left  <= '0;
            r_pending    <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_target     <= n_target;
            r_control    <= n_control;
            r_rest_start <= n_rest_start;
            r_rest_left  <= n_rest_left;
            r_pending    <= n_pending;
        end
    end

    // result is the state after the update
    assign o_result.process_state     = n_phase;
    assign o_result.target_temp       = n_target;
    assign o_result.control_on        = n_control;
    assign o_result.rest_left_seconds = n_rest_left;
    assign o_result.command_rejected  = rejected;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// testbench for mash_rest_sequencer: drives items and register writes, tracks the
// rest profile in its own model and checks every result; depends on mrs_pkg and the rtl
import mrs_pkg::*;

// tracks the sequencer state and holds the results that are still due
class profile_tracker;
    localparam int HOLD_CAP = (60 * MAX_REST_MINUTES > 16383) ? 16383 : 60 * MAX_REST_MINUTES;

    // register copies
    t_temp     rest_temp[3];
    t_minutes  rest_min[3];
    t_temp     idle_temp;
    // process state
    t_phase    phase;
    int        target;
    bit        control;
    bit [31:0] hold_start;
    int        hold_left;
    bit        finish_armed;
    // results waiting for the block
    t_result   due_results[$];
    int        mismatches;

    function new();
        rest_temp[0] = RST_REST_TEMP_1;
        rest_temp[1] = RST_REST_TEMP_2;
        rest_temp[2] = RST_REST_TEMP_3;
        rest_min[0]  = RST_REST_MIN_1;
        rest_min[1]  = RST_REST_MIN_2;
        rest_min[2]  = RST_REST_MIN_3;
        idle_temp    = RST_IDLE_TARGET;
        phase        = PH_IDLE;
        target       = limit_temp(idle_temp);
        control      = 1'b0;
        hold_start   = '0;
        hold_left    = 0;
        finish_armed = 1'b0;
        mismatches   = 0;
    endfunction

    function int limit_temp(int t);
        if (t > MAX_TARGET) return MAX_TARGET;
        if (t < MIN_TARGET) return MIN_TARGET;
        return t;
    endfunction

    function void write_reg(t_cfg_index idx, logic [11:0] val);
        case (idx)
            CFG_REST_TEMP_1: rest_temp[0] = val;
            CFG_REST_TEMP_2: rest_temp[1] = val;
            CFG_REST_TEMP_3: rest_temp[2] = val;
            CFG_REST_MIN_1:  rest_min[0]  = val[7:0];
            CFG_REST_MIN_2:  rest_min[1]  = val[7:0];
            CFG_REST_MIN_3:  rest_min[2]  = val[7:0];
            CFG_IDLE_TARGET: idle_temp    = val;
            default: ;
        endcase
    endfunction

    function void restart_process();
        phase   = PH_IDLE;
        control = 1'b0;
        target  = limit_temp(idle_temp);
    endfunction

    // one sample tick: heat, hold and the done handling
    function void advance_tick(int temp, bit [31:0] now);
        int     idx;
        int     mins;
        longint start_l;
        longint now_l;
        longint span;
        if (phase != PH_IDLE && phase != PH_DONE) begin
            idx  = (int'(phase) - 1) / 2;
            mins = (rest_min[idx] > MAX_REST_MINUTES) ? MAX_REST_MINUTES : rest_min[idx];
            target = limit_temp(rest_temp[idx]);
            finish_armed = 1'b0;
            if (phase[0]) begin
                hold_left = 0;
                if (temp >= target) begin
                    hold_start = now;
                    // zero-length rest jumps straight to the next target
                    if (idx < 2 && mins == 0)
                        target = limit_temp(rest_temp[idx + 1]);
                    hold_left = (60 * mins > HOLD_CAP) ? HOLD_CAP : 60 * mins;
                    phase = t_phase'(phase + 1);
                end
            end else begin
                // end time has no 32-bit wrap
                start_l = hold_start;
                now_l   = now;
                span    = start_l + 60 * mins - now_l;
                if (span <= 0) begin
                    if (idx < 2)
                        target = limit_temp(rest_temp[idx + 1]);
                    hold_left = 0;
                    phase = t_phase'(phase + 1);
                end else begin
                    hold_left = (span > HOLD_CAP) ? HOLD_CAP : int'(span);
                end
            end
        end
        if (finish_armed) begin
            restart_process();
            finish_armed = 1'b0;
        end
        if (phase == PH_DONE)
            finish_armed = 1'b1;
    endfunction

    // accepted input item: update the state and queue its result
    function void take_item(t_item it);
        t_result r;
        bit      rejected;
        rejected = 1'b0;
        case (it.opcode)
            OP_TICK: advance_tick(it.temperature, it.now_seconds);
            OP_SET_STATE: begin
                if (it.new_state > 7) begin
                    rejected = 1'b1;
                end else begin
                    phase = it.new_state[2:0];
                    if (it.new_state == 0) begin
                        restart_process();
                    end else begin
                        control = 1'b1;
                        if (!it.new_state[0])
                            hold_start = it.now_seconds;
                    end
                end
            end
            OP_SET_CONTROL: begin
                if (phase != PH_IDLE) rejected = 1'b1;
                else control = it.enable_value;
            end
            default: begin
                if (phase != PH_IDLE) rejected = 1'b1;
                else target = limit_temp(it.new_target);
            end
        endcase
        r.process_state     = phase;
        r.target_temp       = t_temp'(target);
        r.control_on        = control;
        r.rest_left_seconds = t_left'(hold_left);
        r.command_rejected  = rejected;
        due_results.push_back(r);
    endfunction

    function void compare_field(string field, logic signed [31:0] want,
                                logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // accepted result item against the oldest one due
    function void match_result(logic [31:0] data, logic flag);
        t_result r;
        if (due_results.size() == 0) begin
            $error("result with nothing due: tdata %h tuser %b", data, flag);
            mismatches++;
            return;
        end
        r = due_results.pop_front();
        compare_field("process_state", r.process_state, data[2:0]);
        compare_field("target_temp", r.target_temp, $signed(data[14:3]));
        compare_field("control_on", r.control_on, data[15]);
        compare_field("rest_left_seconds", r.rest_left_seconds, data[29:16]);
        compare_field("command_rejected", r.command_rejected, flag);
    endfunction
endclass

module testbench;
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata;   // temperature, now_seconds, new_state, enable_value, new_target
    logic [1:0]            s_axis_tuser;   // opcode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;   // process_state, target_temp, control_on, rest_left_seconds
    logic                  m_axis_tuser;   // command_rejected

    profile_tracker board;
    int             send_idle_pct;
    int             recv_idle_pct;
    bit [31:0]      clock_now;

    mash_rest_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // result side: check accepted items, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            board.match_result(m_axis_tdata, m_axis_tuser);
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // one input item, with random gaps ahead of it
    task automatic drive_item(input t_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, it.new_target, it.enable_value, it.new_state,
                          it.now_seconds, it.temperature};
        s_axis_tuser  <= it.opcode;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        board.take_item(it);
    endtask

    task automatic send_fields(input t_opcode op, input int temp, input bit [31:0] now,
                               input int st, input bit en, input int tg);
        t_item it;
        it.opcode       = op;
        it.temperature  = t_temp'(temp);
        it.now_seconds  = now;
        it.new_state    = st[3:0];
        it.enable_value = en;
        it.new_target   = t_temp'(tg);
        drive_item(it);
    endtask

    // wait for every result, then for the pipeline to settle
    task automatic wait_drained(input int extra);
        while (board.due_results.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [11:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        board.write_reg(idx, val);
    endtask

    task automatic load_regs(input logic [11:0] t1, input logic [11:0] t2,
                             input logic [11:0] t3, input logic [7:0] m1,
                             input logic [7:0] m2, input logic [7:0] m3,
                             input logic [11:0] idle);
        write_reg(CFG_REST_TEMP_1, t1);
        write_reg(CFG_REST_TEMP_2, t2);
        write_reg(CFG_REST_TEMP_3, t3);
        write_reg(CFG_REST_MIN_1, {4'h0, m1});
        write_reg(CFG_REST_MIN_2, {4'h0, m2});
        write_reg(CFG_REST_MIN_3, {4'h0, m3});
        write_reg(CFG_IDLE_TARGET, idle);
        i_cfg_wr_en <= 1'b0;
    endtask

    // random item, steered toward full brew runs
    task automatic send_random();
        int      r;
        int      rn;
        int      rt;
        int      temp;
        int      st;
        t_opcode op;
        r  = $urandom_range(0, 99);
        rn = $urandom_range(0, 99);
        rt = $urandom_range(0, 99);
        st = $urandom_range(0, 15);
        // wall clock mostly runs forward, sometimes backward or jumps
        if (rn < 4) clock_now = clock_now - $urandom_range(0, 3000);
        else if (rn < 7) clock_now = $urandom;
        else if (rn < 9) clock_now = 32'hFFFF_FFFF - $urandom_range(0, 2000);
        else clock_now = clock_now + $urandom_range(0, 1500);
        if (rt < 15) temp = $urandom_range(0, 4095);
        else if (rt < 60) temp = $urandom_range(0, 2880) - 880;
        else temp = $urandom_range(1500, 2047);
        if (board.phase == PH_IDLE) begin
            if (r < 35) begin
                op = OP_SET_STATE;
                if ($urandom_range(0, 99) < 75) st = 1;
            end else if (r < 50) op = OP_SET_CONTROL;
            else if (r < 65) op = OP_SET_TARGET;
            else op = OP_TICK;
        end else begin
            if (r < 80) op = OP_TICK;
            else if (r < 88) begin
                op = OP_SET_STATE;
                if ($urandom_range(0, 1) == 1) st = $urandom_range(0, 7);
            end else if (r < 94) op = OP_SET_CONTROL;
            else op = OP_SET_TARGET;
        end
        send_fields(op, temp, clock_now, st, 1'($urandom_range(0, 1)),
                    $urandom_range(0, 4095));
    endtask

    // stimulus
    initial begin
        board = new();
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= CFG_REST_TEMP_1;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_TICK;
        m_axis_tready <= 1'b0;
        send_idle_pct = 9;
        recv_idle_pct = 84;
        clock_now     = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed run with the reset registers
        send_fields(OP_TICK, 0, 100, 0, 0, 0);              // tick in idle changes nothing
        send_fields(OP_SET_CONTROL, 0, 100, 0, 1, 0);
        send_fields(OP_SET_CONTROL, 0, 100, 0, 0, 0);
        send_fields(OP_SET_TARGET, 0, 100, 0, 0, 2047);     // clamps to max
        send_fields(OP_SET_TARGET, 0, 100, 0, 0, -2048);    // clamps to min
        send_fields(OP_SET_STATE, 0, 100, 8, 0, 0);         // bad state rejected
        send_fields(OP_SET_STATE, 0, 100, 15, 0, 0);
        send_fields(OP_SET_STATE, 0, 1000, 1, 0, 0);        // start heating
        send_fields(OP_SET_CONTROL, 0, 1000, 0, 0, 0);      // rejected while running
        send_fields(OP_SET_TARGET, 0, 1000, 0, 0, 500);     // rejected while running
        send_fields(OP_TICK, -2048, 1010, 0, 0, 0);
        send_fields(OP_TICK, 799, 1020, 0, 0, 0);
        send_fields(OP_TICK, 800, 2000, 0, 0, 0);           // reaches rest 1
        send_fields(OP_TICK, 0, 1500, 0, 0, 0);             // clock ran backward
        send_fields(OP_TICK, 0, 3199, 0, 0, 0);
        send_fields(OP_TICK, 0, 3200, 0, 0, 0);             // rest 1 over
        send_fields(OP_TICK, 2047, 4000, 0, 0, 0);
        send_fields(OP_SET_STATE, 0, 32'hFFFF_FFFF, 4, 0, 0); // hold start at the top
        send_fields(OP_TICK, 0, 5, 0, 0, 0);                // seconds left saturate
        send_fields(OP_TICK, 0, 32'hFFFF_FFFF, 0, 0, 0);    // end time past 32 bits
        send_fields(OP_SET_STATE, 0, 0, 6, 0, 0);
        send_fields(OP_TICK, 0, 1200, 0, 0, 0);             // reaches done
        send_fields(OP_TICK, 0, 1300, 0, 0, 0);
        send_fields(OP_TICK, 0, 1400, 0, 0, 0);             // tick in idle after the process reset
        send_fields(OP_SET_STATE, 0, 1500, 3, 0, 0);
        send_fields(OP_SET_STATE, 0, 1500, 0, 0, 0);        // reset while running

        // random runs over several register settings
        for (int setting = 0; setting < 6; setting++) begin
            if (setting == 2) begin
                send_idle_pct = 84;
                recv_idle_pct = 9;
            end
            if (setting == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (setting > 0) begin
                wait_drained(4);
                case (setting)
                    1: load_regs(12'h800, 12'h7FF, 12'h000, 8'd0, 8'd0, 8'd255, 12'h7FF);
                    3: load_regs(12'd2000, 12'hC90, 12'h800, 8'd255, 8'd1, 8'd0, 12'h800);
                    5: load_regs(12'd400, 12'd800, 12'd1200, 8'd1, 8'd2, 8'd3, 12'hC90);
                    default: load_regs(12'($urandom), 12'($urandom), 12'($urandom),
                                       8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)),
                                       12'($urandom));
                endcase
            end
            repeat (305) send_random();
            s_axis_tvalid <= 1'b0;
        end

        wait_drained(8);
        if (board.mismatches == 0 && board.due_results.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end
endmodule
